FILE: rtl/core/irdla_pkg.sv
package irdla_pkg;

    // defaults for the top level parameters
    localparam int DEFAULT_WINDOW   = 20;
    localparam int DEFAULT_ADC_BITS = 10;

    // field widths
    localparam int CODE_W      = 10;
    localparam int DIST_W      = 8;
    localparam int SAMPLE_W    = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    // largest clamped sample, 255 cm in q8.8
    localparam int SAMPLE_MAX = 65280;

    // serial divider: nine quotient bits, bit 8 means saturate
    localparam int QUOT_W    = 9;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUOT_W - 1);
    localparam logic [DIST_W-1:0] DIST_SAT = 8'hFF;

    // register reset values
    localparam logic [CODE_W-1:0] NEAR_CUTOFF_RESET = 10'd80;
    localparam logic [DIST_W-1:0] MIN_DIST_RESET    = 8'd16;
    localparam logic [DIST_W-1:0] MAX_DIST_RESET    = 8'd150;

    // calibration curve d = 1512.89 / x^0.424 - 74, in fixed point
    localparam int      CAL_BITS    = 10;
    localparam longint  LOG2_A_Q16  = 692263;
    localparam longint  EXP_C_Q16   = 27787;
    localparam longint unsigned LN2_Q32    = 64'd2977044472;
    localparam longint unsigned OFFSET_Q8  = 64'd18944;
    localparam int      EXP_TERMS   = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NEAR_CUTOFF = 2'd0,
        CFG_MIN_DIST    = 2'd1,
        CFG_MAX_DIST    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [CODE_W-1:0] near_cutoff;
        logic [DIST_W-1:0] min_dist;
        logic [DIST_W-1:0] max_dist;
    } cfg_t;

    typedef enum logic [2:0] {
        BACK_IDLE,
        BACK_UPDATE,
        BACK_SCALE,
        BACK_PREP,
        BACK_DIVIDE,
        BACK_DONE
    } back_state_t;

    // shift and subtract quotient, used while building the rom
    function automatic longint unsigned udiv64(input longint unsigned dividend,
                                               input longint unsigned divisor);
        longint unsigned quot;
        longint unsigned rem;
        int b;
        quot = 0;
        rem  = 0;
        for (b = 63; b >= 0; b--) begin
            rem  = (rem << 1) | ((dividend >> b) & 64'd1);
            quot = quot << 1;
            if (rem >= divisor) begin
                rem  = rem - divisor;
                quot = quot | 64'd1;
            end
        end
        return quot;
    endfunction

    // one rom entry, evaluated at elaboration only
    function automatic logic [SAMPLE_W-1:0] curve_entry(input int unsigned code,
                                                        input int adc_bits);
        longint unsigned y;
        longint unsigned z;
        longint unsigned term;
        longint unsigned e;
        longint unsigned val;
        longint unsigned frac_t;
        longint unsigned ip;
        longint s;
        longint t;
        int unsigned n;
        int unsigned frac;
        int unsigned lg;
        int i;
        int k;
        if (code == 0) begin
            return 16'hFFFF;
        end
        // integer log2 by leading one, fraction by repeated squaring
        n = 0;
        for (i = 0; i < 31; i++) begin
            if ((code >> (i + 1)) != 0) begin
                n = i + 1;
            end
        end
        frac = 0;
        y = longint'(code) << (30 - n);
        for (k = 0; k < 16; k++) begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30)) begin
                y = y >> 1;
                frac = frac | 1;
            end
        end
        lg = (n << 16) | frac;
        s = longint'(lg) - longint'(adc_bits - CAL_BITS) * 65536;
        t = LOG2_A_Q16 * 65536 - s * EXP_C_Q16;
        if (t < 0) begin
            return 16'h0000;
        end
        ip = longint'(t) >> 32;
        if (ip >= 9) begin
            return 16'hFFFF;
        end
        frac_t = longint'(t) & 64'hFFFF_FFFF;
        z = (frac_t * LN2_Q32) >> 32;
        term = 64'd1 << 32;
        e = term;
        for (k = 1; k <= EXP_TERMS; k++) begin
            term = udiv64((term * z) >> 32, longint'(k));
            e = e + term;
        end
        val = ((e << ip) + (64'd1 << 23)) >> 24;
        if (val <= OFFSET_Q8) begin
            return 16'h0000;
        end
        val = val - OFFSET_Q8;
        if (val > 64'hFFFF) begin
            return 16'hFFFF;
        end
        return val[SAMPLE_W-1:0];
    endfunction

endpackage

FILE: rtl/core/irdla_front.sv
module irdla_front import irdla_pkg::*; #(
    parameter int ADC_BITS = DEFAULT_ADC_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CODE_W-1:0]   s_adc_code,
    output logic                q_push,
    output logic [SAMPLE_W-1:0] q_push_data,
    input  logic                q_full
);

    localparam int ROM_SIZE = 1 << ADC_BITS;

    typedef logic [SAMPLE_W-1:0] rom_arr_t [ROM_SIZE];

    function automatic rom_arr_t build_rom();
        rom_arr_t r;
        int i;
        for (i = 0; i < ROM_SIZE; i++) begin
            r[i] = curve_entry(int'(i), ADC_BITS);
        end
        return r;
    endfunction

    localparam rom_arr_t CURVE_ROM = build_rom();

    logic                f_valid_reg;
    logic                f_valid_next;
    logic                below_reg;
    logic [SAMPLE_W-1:0] rom_data_reg;
    logic [ADC_BITS-1:0] rom_addr;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic                s_accept;

    assign rom_addr = ADC_BITS'(s_adc_code);
    assign lo       = {cfg.min_dist, 8'h00};
    assign hi       = {cfg.max_dist, 8'h00};

    assign q_push   = f_valid_reg && !q_full;
    assign s_ready  = !f_valid_reg || !q_full;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        f_valid_next = f_valid_reg;
        if (s_accept) begin
            f_valid_next = 1'b1;
        end else if (q_push) begin
            f_valid_next = 1'b0;
        end
    end

    // min is tested before max, so a crossed pair still lands on one of them
    always_comb begin
        if (below_reg) begin
            q_push_data = hi;
        end else if (rom_data_reg < lo) begin
            q_push_data = lo;
        end else if (rom_data_reg > hi) begin
            q_push_data = hi;
        end else begin
            q_push_data = rom_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rom_data_reg <= CURVE_ROM[rom_addr];
            below_reg    <= (s_adc_code < cfg.near_cutoff);
        end
    end

endmodule

FILE: rtl/core/irdla_queue.sv
module irdla_queue import irdla_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  logic [SAMPLE_W-1:0] push_data,
    output logic                full,
    input  logic                pop,
    output logic [SAMPLE_W-1:0] pop_data,
    output logic                empty
);

    logic [SAMPLE_W-1:0] entry_reg [2];
    logic                wr_ptr_reg;
    logic                wr_ptr_next;
    logic                rd_ptr_reg;
    logic                rd_ptr_next;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/irdla_back.sv
module irdla_back import irdla_pkg::*; #(
    parameter int WINDOW = DEFAULT_WINDOW
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                q_empty,
    output logic                q_pop,
    input  logic [SAMPLE_W-1:0] q_pop_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DIST_W-1:0]   m_distance_cm,
    output logic [DIST_W-1:0]   m_distance_fraction
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * SAMPLE_MAX + 1);
    localparam int BASE_W = SAMPLE_W + FILL_W;
    localparam int SPAN_W = DIST_W + FILL_W;
    localparam int DIV_W  = SUM_W + FILL_W + 18;
    localparam int CM_W   = SUM_W + FILL_W;

    back_state_t state_reg;
    back_state_t state_next;

    logic [SAMPLE_W-1:0] ring_mem [WINDOW];

    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] old_reg;
    logic [BASE_W-1:0]   base_reg;
    logic [BASE_W-1:0]   base_next;
    logic [SPAN_W-1:0]   span_fill_reg;
    logic [SPAN_W-1:0]   span_fill_next;
    logic                frac_ok_reg;
    logic                frac_ok_next;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    rem_next;
    logic [DIV_W-1:0]    dsh_reg;
    logic [DIV_W-1:0]    dsh_next;
    logic [QUOT_W-1:0]   q_reg;
    logic [QUOT_W-1:0]   q_next;
    logic [CM_W-1:0]     crem_reg;
    logic [CM_W-1:0]     crem_next;
    logic [CM_W-1:0]     cdsh_reg;
    logic [CM_W-1:0]     cdsh_next;
    logic [QUOT_W-1:0]   cq_reg;
    logic [QUOT_W-1:0]   cq_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [DIST_W-1:0]   m_cm_reg;
    logic [DIST_W-1:0]   m_cm_next;
    logic [DIST_W-1:0]   m_frac_reg;
    logic [DIST_W-1:0]   m_frac_next;

    logic                ring_full;
    logic [DIST_W-1:0]   span;
    logic [SUM_W-1:0]    diff;
    logic [DIV_W-1:0]    num;
    logic [DIV_W-1:0]    den;

    assign m_valid             = m_valid_reg;
    assign m_distance_cm       = m_cm_reg;
    assign m_distance_fraction = m_frac_reg;

    assign ring_full = (fill_reg == FILL_W'(WINDOW));
    assign span      = cfg.max_dist - cfg.min_dist;
    assign diff      = SUM_W'(DIV_W'(sum_reg) - DIV_W'(base_reg));
    // diff * 255
    assign num       = (DIV_W'(diff) << 8) - DIV_W'(diff);
    assign den       = DIV_W'(span_fill_reg) << 8;

    always_comb begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        base_next      = base_reg;
        span_fill_next = span_fill_reg;
        frac_ok_next   = frac_ok_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        crem_next      = crem_reg;
        cdsh_next      = cdsh_reg;
        cq_next        = cq_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_cm_next      = m_cm_reg;
        m_frac_next    = m_frac_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            BACK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = BACK_UPDATE;
                end
            end
            BACK_UPDATE: begin
                // drop the oldest sample once the ring is full
                sum_next = sum_reg - (ring_full ? SUM_W'(old_reg) : '0)
                           + SUM_W'(sample_reg);
                slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                if (!ring_full) begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = BACK_SCALE;
            end
            BACK_SCALE: begin
                base_next      = BASE_W'({cfg.min_dist, 8'h00}) * BASE_W'(fill_reg);
                span_fill_next = SPAN_W'(span) * SPAN_W'(fill_reg);
                // floor(sum / (fill * 256)) as (sum >> 8) / fill
                crem_next      = CM_W'(sum_reg >> 8);
                cdsh_next      = CM_W'(fill_reg) << (QUOT_W - 1);
                state_next     = BACK_PREP;
            end
            BACK_PREP: begin
                frac_ok_next = (cfg.max_dist > cfg.min_dist) &&
                               (DIV_W'(sum_reg) > DIV_W'(base_reg));
                // round half up: (2 * num + den) / (2 * den)
                rem_next     = (num << 1) + den;
                dsh_next     = den << QUOT_W;
                q_next       = '0;
                cq_next      = '0;
                cnt_next     = '0;
                state_next   = BACK_DIVIDE;
            end
            BACK_DIVIDE: begin
                if (rem_reg >= dsh_reg) begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = {q_reg[QUOT_W-2:0], 1'b1};
                end else begin
                    q_next   = {q_reg[QUOT_W-2:0], 1'b0};
                end
                if (crem_reg >= cdsh_reg) begin
                    crem_next = crem_reg - cdsh_reg;
                    cq_next   = {cq_reg[QUOT_W-2:0], 1'b1};
                end else begin
                    cq_next   = {cq_reg[QUOT_W-2:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                cdsh_next = cdsh_reg >> 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = BACK_DONE;
                end
            end
            BACK_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_cm_next    = cq_reg[QUOT_W-1] ? DIST_SAT : cq_reg[DIST_W-1:0];
                    if (!frac_ok_reg) begin
                        m_frac_next = '0;
                    end else begin
                        m_frac_next = q_reg[QUOT_W-1] ? DIST_SAT : q_reg[DIST_W-1:0];
                    end
                    state_next = BACK_IDLE;
                end
            end
            default: begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BACK_IDLE;
            slot_reg    <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg      <= base_next;
        span_fill_reg <= span_fill_next;
        frac_ok_reg   <= frac_ok_next;
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        q_reg         <= q_next;
        crem_reg      <= crem_next;
        cdsh_reg      <= cdsh_next;
        cq_reg        <= cq_next;
        cnt_reg       <= cnt_next;
        m_cm_reg      <= m_cm_next;
        m_frac_reg    <= m_frac_next;
    end

    // ring read on pop, write in the next cycle, in update
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            sample_reg <= q_pop_data;
            old_reg    <= ring_mem[slot_reg];
        end
        if (state_reg == BACK_UPDATE) begin
            ring_mem[slot_reg] <= sample_reg;
        end
    end

endmodule

FILE: rtl/core/ir_distance_linearize_average.sv
// flow: the front end and a two-entry queue take new words while the back end is
// busy with one word at a time; its nine-step serial divider forms the mean and
// the span fraction
// reset: synchronous active-low aresetn clears control, running sum, fill count,
// write slot and loads the register defaults; the sample ring is not cleared
module ir_distance_linearize_average import irdla_pkg::*; #(
    parameter int WINDOW   = DEFAULT_WINDOW,
    parameter int ADC_BITS = DEFAULT_ADC_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CODE_W-1:0]      s_adc_code,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [DIST_W-1:0]      m_distance_cm,
    output logic [DIST_W-1:0]      m_distance_fraction
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic                q_push;
    logic [SAMPLE_W-1:0] q_push_data;
    logic                q_full;
    logic                q_pop;
    logic [SAMPLE_W-1:0] q_pop_data;
    logic                q_empty;

    // writes beyond the register list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NEAR_CUTOFF: cfg_next.near_cutoff = cfg_wdata;
                CFG_MIN_DIST:    cfg_next.min_dist    = cfg_wdata[DIST_W-1:0];
                CFG_MAX_DIST:    cfg_next.max_dist    = cfg_wdata[DIST_W-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_cutoff <= NEAR_CUTOFF_RESET;
            cfg_reg.min_dist    <= MIN_DIST_RESET;
            cfg_reg.max_dist    <= MAX_DIST_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    irdla_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_adc_code  (s_adc_code),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .q_full      (q_full)
    );

    irdla_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    irdla_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg_reg),
        .q_empty             (q_empty),
        .q_pop               (q_pop),
        .q_pop_data          (q_pop_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_distance_cm       (m_distance_cm),
        .m_distance_fraction (m_distance_fraction)
    );

endmodule

FILE: test/ir_distance_linearize_average_tb.sv
`timescale 1ns / 1ps

module ir_distance_linearize_average_tb;
    import irdla_pkg::*;

    localparam int WINDOW   = DEFAULT_WINDOW;
    localparam int ADC_BITS = DEFAULT_ADC_BITS;
    localparam int ROM_DEPTH = 1 << ADC_BITS;

    // calibration curve constants, q16, q32 and q8
    localparam longint CURVE_LOG2_A = 692263;
    localparam longint CURVE_EXP_C  = 27787;
    localparam longint unsigned CURVE_LN2   = 64'd2977044472;
    localparam longint unsigned CURVE_SHIFT = 64'd18944;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 3000;

    typedef struct {
        logic [DIST_W-1:0] cm;
        logic [DIST_W-1:0] fraction;
    } reading_t;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic [CODE_W-1:0] s_adc_code;
    logic m_valid;
    logic m_ready;
    logic [DIST_W-1:0] m_distance_cm;
    logic [DIST_W-1:0] m_distance_fraction;

    // predictor state
    logic [SAMPLE_W-1:0] curve_rom [ROM_DEPTH];
    logic [CODE_W-1:0] cutoff_code;
    logic [DIST_W-1:0] min_cm;
    logic [DIST_W-1:0] max_cm;
    logic [SAMPLE_W-1:0] window_samples [WINDOW];
    longint unsigned window_sum;
    int unsigned next_slot;
    int unsigned stored_count;

    reading_t expected_readings[$];
    reading_t want;
    int failures;
    bit tx_gaps;
    bit rx_stalls;
    bit hold_off_req;

    ir_distance_linearize_average #(
        .WINDOW(WINDOW),
        .ADC_BITS(ADC_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_adc_code(s_adc_code),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_distance_cm(m_distance_cm),
        .m_distance_fraction(m_distance_fraction)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // distance in q8.8 for one code, curve minus offset, saturated
    function automatic logic [SAMPLE_W-1:0] calibrated_q88(int unsigned code);
        longint unsigned sq;
        longint unsigned frac_t;
        longint unsigned z;
        longint unsigned term;
        longint unsigned e_sum;
        longint unsigned val;
        longint lg;
        longint t;
        int unsigned msb;
        int unsigned lg_frac;
        int ip;
        int k;
        if (code == 0) begin
            return 16'hFFFF;
        end
        msb = 0;
        while (msb < 31 && (code >> (msb + 1)) != 0) begin
            msb++;
        end
        // fraction bits of log2 by repeated squaring of the normalized code
        sq = longint'(code) << (30 - msb);
        lg_frac = 0;
        repeat (16) begin
            sq = (sq * sq) >> 30;
            lg_frac = lg_frac << 1;
            if (sq >= (64'd1 << 31)) begin
                sq = sq >> 1;
                lg_frac = lg_frac | 1;
            end
        end
        lg = (longint'(msb) << 16) + longint'(lg_frac) - longint'(ADC_BITS - 10) * 65536;
        t = CURVE_LOG2_A * 65536 - lg * CURVE_EXP_C;
        if (t < 0) begin
            return 16'h0000;
        end
        if ((t >>> 32) >= 9) begin
            return 16'hFFFF;
        end
        ip = int'(t >>> 32);
        frac_t = t & 64'hFFFF_FFFF;
        // 2^frac as a truncated taylor series of e^(frac*ln2)
        z = (frac_t * CURVE_LN2) >> 32;
        term = 64'd1 << 32;
        e_sum = term;
        for (k = 1; k <= 16; k++) begin
            term = ((term * z) >> 32) / longint'(k);
            e_sum = e_sum + term;
        end
        val = ((e_sum << ip) + (64'd1 << 23)) >> 24;
        if (val <= CURVE_SHIFT) begin
            return 16'h0000;
        end
        val = val - CURVE_SHIFT;
        if (val > 64'hFFFF) begin
            return 16'hFFFF;
        end
        return val[SAMPLE_W-1:0];
    endfunction

    // stores one clamped sample and returns the new window average
    function automatic reading_t next_average(logic [CODE_W-1:0] code);
        logic [SAMPLE_W-1:0] lo_q;
        logic [SAMPLE_W-1:0] hi_q;
        logic [SAMPLE_W-1:0] sample;
        longint unsigned cm;
        longint unsigned fr;
        longint unsigned base;
        longint unsigned num;
        longint unsigned den;
        reading_t r;
        lo_q = {min_cm, 8'h00};
        hi_q = {max_cm, 8'h00};
        if (code < cutoff_code) begin
            sample = hi_q;
        end else begin
            sample = curve_rom[code];
            if (sample < lo_q) begin
                sample = lo_q;
            end else if (sample > hi_q) begin
                sample = hi_q;
            end
        end
        if (stored_count >= WINDOW) begin
            window_sum = window_sum - window_samples[next_slot];
        end
        window_samples[next_slot] = sample;
        window_sum = window_sum + sample;
        next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
        if (stored_count < WINDOW) begin
            stored_count++;
        end
        cm = window_sum / (longint'(stored_count) * 256);
        if (cm > 255) begin
            cm = 255;
        end
        fr = 0;
        base = longint'(lo_q) * stored_count;
        if (max_cm > min_cm && window_sum > base) begin
            num = (window_sum - base) * 255;
            den = longint'(max_cm - min_cm) * 256 * stored_count;
            fr = (2 * num + den) / (2 * den);
            if (fr > 255) begin
                fr = 255;
            end
        end
        r.cm = cm[DIST_W-1:0];
        r.fraction = fr[DIST_W-1:0];
        return r;
    endfunction

    // results are checked before the word accepted at the same edge is predicted
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected word cm=%0d fraction=%0d", $time,
                         m_distance_cm, m_distance_fraction);
                failures++;
            end else begin
                want = expected_readings.pop_front();
                if (m_distance_cm !== want.cm) begin
                    $display("%0t: distance_cm expected %0d actual %0d", $time,
                             want.cm, m_distance_cm);
                    failures++;
                end
                if (m_distance_fraction !== want.fraction) begin
                    $display("%0t: distance_fraction expected %0d actual %0d", $time,
                             want.fraction, m_distance_fraction);
                    failures++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            expected_readings.push_back(next_average(s_adc_code));
        end
    end

    // result side: random stall bursts, or one long hold-off on request
    initial begin : receiver
        int burst;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
                m_ready = 1'b1;
            end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                burst = $urandom_range(1, 14);
                repeat (burst) @(negedge aclk);
                m_ready = 1'b1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** ir_distance_linearize_average: FAILED **");
        $finish;
    end

    task automatic send_code(logic [CODE_W-1:0] code);
        int gap;
        @(negedge aclk);
        s_valid = 1'b1;
        s_adc_code = code;
        do @(posedge aclk); while (!s_ready);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    function automatic logic [CODE_W-1:0] random_code();
        int pick;
        int c;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            c = $urandom_range(0, 1023);
        end else if (pick < 8) begin
            // around the cutoff
            c = int'(cutoff_code) + int'($urandom_range(0, 16)) - 8;
            if (c < 0) begin
                c = 0;
            end
            if (c > 1023) begin
                c = 1023;
            end
        end else begin
            c = $urandom_range(0, 120);
        end
        return c[CODE_W-1:0];
    endfunction

    task automatic send_random(int count);
        repeat (count) send_code(random_code());
    endtask

    // stop offering and wait until the block is idle again
    task automatic drain_readings();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_readings.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        case (idx)
            CFG_NEAR_CUTOFF: cutoff_code = value;
            CFG_MIN_DIST: min_cm = value[DIST_W-1:0];
            CFG_MAX_DIST: max_cm = value[DIST_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_registers(int cutoff, int lo_cm, int hi_cm);
        drain_readings();
        write_register(CFG_NEAR_CUTOFF, cutoff[CFG_DATA_W-1:0]);
        write_register(CFG_MIN_DIST, lo_cm[CFG_DATA_W-1:0]);
        write_register(CFG_MAX_DIST, hi_cm[CFG_DATA_W-1:0]);
    endtask

    task automatic test_defaults();
        send_code(10'd79);
        send_code(10'd80);
        send_code(10'd0);
        send_code(10'd1023);
        send_code(10'd300);
    endtask

    task automatic test_curve_extremes();
        set_registers(0, 0, 255);
        // code zero and the lowest codes saturate the curve
        send_code(10'd0);
        send_code(10'd1);
        send_code(10'd2);
        send_code(10'd12);
        send_code(10'd13);
        send_code(10'd31);
        send_code(10'd63);
        send_code(10'd127);
        send_code(10'd255);
        send_code(10'd511);
        send_code(10'd1023);
        send_code(10'h155);
        send_code(10'h2AA);
    endtask

    task automatic test_register_corners();
        // upper data bits set on the narrow registers
        drain_readings();
        write_register(CFG_NEAR_CUTOFF, 10'h3FF);
        write_register(CFG_MIN_DIST, 10'h3FE);
        write_register(CFG_MAX_DIST, 10'h3FF);
        send_random(25);
        // min above max: every sample is one of the two
        set_registers(40, 200, 50);
        send_random(25);
        // empty span
        set_registers(80, 100, 100);
        send_random(25);
        set_registers(0, 0, 1);
        send_random(25);
    endtask

    task automatic test_unused_index();
        drain_readings();
        write_register(CFG_UNUSED_INDEX, 10'h155);
        write_register(CFG_UNUSED_INDEX, 10'h2AA);
        send_random(10);
    endtask

    task automatic test_mean_below_min();
        set_registers(0, 0, 255);
        repeat (WINDOW) send_code(10'd1023);
        drain_readings();
        write_register(CFG_MIN_DIST, 10'd200);
        repeat (5) send_code(10'd1023);
    endtask

    task automatic test_backpressure();
        drain_readings();
        tx_gaps = 1'b0;
        hold_off_req = 1'b1;
        send_random(40);
        // sender waits for every word before going on
        drain_readings();
        tx_gaps = 1'b1;
        send_random(10);
    endtask

    task automatic test_random();
        int phase;
        int style;
        for (phase = 0; phase < 8; phase++) begin
            style = $urandom_range(0, 3);
            if (style < 2) begin
                set_registers($urandom_range(0, 200), $urandom_range(5, 40),
                              $urandom_range(80, 255));
            end else if (style == 2) begin
                set_registers($urandom_range(0, 1023), $urandom_range(0, 254),
                              $urandom_range(1, 255));
            end else begin
                set_registers($urandom_range(0, 1) * 1023, $urandom_range(0, 1) * 254,
                              $urandom_range(0, 1) * 254 + 1);
            end
            if (phase == 7) begin
                // last part of the run runs at full rate
                tx_gaps = 1'b0;
                rx_stalls = 1'b0;
            end else begin
                tx_gaps = ($urandom_range(0, 3) != 0);
                rx_stalls = ($urandom_range(0, 3) != 0);
            end
            send_random(200);
        end
    endtask

    initial begin : main
        int i;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_NEAR_CUTOFF;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_adc_code = '0;
        failures = 0;
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        hold_off_req = 1'b0;
        for (i = 0; i < ROM_DEPTH; i++) begin
            curve_rom[i] = calibrated_q88(i);
        end
        cutoff_code = NEAR_CUTOFF_RESET;
        min_cm = MIN_DIST_RESET;
        max_cm = MAX_DIST_RESET;
        window_sum = 0;
        next_slot = 0;
        stored_count = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_defaults();
        test_curve_extremes();
        test_register_corners();
        test_unused_index();
        test_mean_below_min();
        test_backpressure();
        test_random();
        drain_readings();

        if (failures == 0) begin
            $display("** ir_distance_linearize_average: PASSED **");
        end else begin
            $display("** ir_distance_linearize_average: FAILED **");
        end
        $finish;
    end

endmodule
